FILE: design/lpcp_pkg.sv
// Shared constants and types for the lidar point camera projection block.
`timescale 1ns / 1ps
package lpcp_pkg;

    localparam int COORD_W = 32;                 // Q16.16 coordinate and coefficient
    localparam int PROD_W  = 2 * COORD_W;        // exact Q32.32 product
    localparam int FRAC_W  = 16;                 // fraction bits dropped by the floor
    localparam int SUM_W   = 50;                 // signed Q34.16 row sum
    localparam int MAG_W   = SUM_W - 1;          // magnitude of a row sum
    localparam int DIM_W   = 14;                 // image size register
    localparam int PIX_W   = 13;                 // pixel index and quotient bits
    localparam int REM_W   = MAG_W + PIX_W;      // divider remainder
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 3 * COORD_W;
    localparam int OUT_W   = 32;                 // two pixel fields padded to bytes

    localparam logic [DIM_W-1:0] MAX_DIM     = DIM_W'(8192);
    localparam logic [DIM_W-1:0] RESET_COLS  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] RESET_ROWS  = DIM_W'(1080);

    typedef enum logic [IDX_W-1:0] {
        REG_U_XY      = 3'd0,
        REG_U_ZC      = 3'd1,
        REG_V_XY      = 3'd2,
        REG_V_ZC      = 3'd3,
        REG_D_XY      = 3'd4,
        REG_D_ZC      = 3'd5,
        REG_COLS      = 3'd6,
        REG_ROWS      = 3'd7
    } reg_idx_t;

    // Pipeline control handed to each stage group.
    typedef struct packed {
        logic en;     // advance all stages this cycle
        logic vld;    // item entering the group
    } pipe_ctl_t;

endpackage

FILE: design/lpcp_dot.sv
// One calibration row dotted with (x, y, z, 1): multiply, floor, add in three stages.
`timescale 1ns / 1ps
module lpcp_dot (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpcp_pkg::pipe_ctl_t                 ctl,
    input  logic [lpcp_pkg::CFG_W-1:0]          coef_xy,
    input  logic [lpcp_pkg::CFG_W-1:0]          coef_zc,
    input  logic signed [lpcp_pkg::COORD_W-1:0] px,
    input  logic signed [lpcp_pkg::COORD_W-1:0] py,
    input  logic signed [lpcp_pkg::COORD_W-1:0] pz,
    output logic                                vld,
    output logic signed [lpcp_pkg::SUM_W-1:0]   sum
);
    import lpcp_pkg::*;

    logic signed [PROD_W-1:0]  px_prod_reg, py_prod_reg, pz_prod_reg;
    logic signed [COORD_W-1:0] cst_reg;
    logic signed [SUM_W-1:0]   part_a_reg, part_b_reg, sum_reg;
    logic [2:0]                vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            px_prod_reg <= $signed(coef_xy[COORD_W-1:0]) * px;
            py_prod_reg <= $signed(coef_xy[CFG_W-1:COORD_W]) * py;
            pz_prod_reg <= $signed(coef_zc[COORD_W-1:0]) * pz;
            cst_reg     <= $signed(coef_zc[CFG_W-1:COORD_W]);
            // arithmetic shift floors toward minus infinity
            part_a_reg  <= SUM_W'(px_prod_reg >>> FRAC_W) + SUM_W'(py_prod_reg >>> FRAC_W);
            part_b_reg  <= SUM_W'(pz_prod_reg >>> FRAC_W) + SUM_W'(cst_reg);
            sum_reg     <= part_a_reg + part_b_reg;
        end
    end

    assign vld = vld_reg[2];
    assign sum = sum_reg;

endmodule

FILE: design/lpcp_div.sv
// Sign fold, range check and pipelined restoring divide giving a 13-bit quotient.
`timescale 1ns / 1ps
module lpcp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lpcp_pkg::pipe_ctl_t               ctl,
    input  logic signed [lpcp_pkg::SUM_W-1:0] num,
    input  logic signed [lpcp_pkg::SUM_W-1:0] den,
    output logic                              vld,
    output logic [lpcp_pkg::PIX_W-1:0]        quot,
    output logic                              ok
);
    import lpcp_pkg::*;

    logic signed [SUM_W-1:0] n_reg;
    logic [MAG_W-1:0]        d_reg;
    logic                    dnz_reg;
    logic                    pre_vld_reg;

    logic [REM_W-1:0]        rem_reg  [0:PIX_W];
    logic [MAG_W-1:0]        dv_reg   [0:PIX_W];
    logic [PIX_W-1:0]        q_reg    [0:PIX_W];
    logic                    ok_reg   [0:PIX_W];
    logic [PIX_W:0]          st_vld_reg;

    logic [REM_W-1:0]        n_mag;
    logic                    ovf;

    assign n_mag = REM_W'(n_reg[MAG_W-1:0]);
    assign ovf   = n_mag >= (REM_W'(d_reg) << PIX_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
            st_vld_reg  <= '0;
        end
        else if (ctl.en)
        begin
            pre_vld_reg <= ctl.vld;
            st_vld_reg  <= {st_vld_reg[PIX_W-1:0], pre_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            // fold a negative depth onto a positive one
            if (den < 0)
            begin
                n_reg <= -num;
                d_reg <= MAG_W'(-den);
            end
            else
            begin
                n_reg <= num;
                d_reg <= MAG_W'(den);
            end
            dnz_reg <= (den != '0);

            rem_reg[0] <= n_mag;
            dv_reg[0]  <= d_reg;
            q_reg[0]   <= '0;
            ok_reg[0]  <= dnz_reg && (n_reg > 0) && !ovf;

            // one quotient bit per stage, most significant first
            for (int i = 0; i < PIX_W; i++)
            begin
                if (rem_reg[i] >= (REM_W'(dv_reg[i]) << (PIX_W - 1 - i)))
                begin
                    rem_reg[i+1] <= rem_reg[i] - (REM_W'(dv_reg[i]) << (PIX_W - 1 - i));
                    q_reg[i+1]   <= q_reg[i] | (PIX_W'(1) << (PIX_W - 1 - i));
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
                dv_reg[i+1] <= dv_reg[i];
                ok_reg[i+1] <= ok_reg[i];
            end
        end
    end

    assign vld  = st_vld_reg[PIX_W];
    assign quot = q_reg[PIX_W];
    assign ok   = ok_reg[PIX_W];

endmodule

FILE: design/lidar_point_camera_projection_top.sv
// Top level of the lidar point to camera pixel projection pipeline.
//
//  Channel   Direction  Payload
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tdata: point_x[31:0], point_y[63:32], point_z[95:64]
//  m_axis    out        tdata: pixel_column[12:0], pixel_row[25:13], zero pad
//                       tuser: in_view
//  cfg       in         cfg_we, cfg_index (register 0..7), cfg_data[63:0]
//
// Takes one point per cycle while the output is not stalled; each point passes through
// three dot-product stages, two sign/range stages, thirteen divider
// stages (one quotient bit each) and the bounds/output stage.
// All stages advance together whenever the output register is empty or being
// taken, so a stall holds every item in place and nothing is dropped.
// Reset clears the valid bits and loads the calibration and image size defaults.
`timescale 1ns / 1ps
module lidar_point_camera_projection_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpcp_pkg::IN_W-1:0]     s_axis_tdata,   // point_x, point_y, point_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpcp_pkg::OUT_W-1:0]    m_axis_tdata,   // pixel_column, pixel_row, pad
    output logic                          m_axis_tuser,   // in_view
    input  logic                          cfg_we,
    input  logic [lpcp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [lpcp_pkg::CFG_W-1:0]    cfg_data
);
    import lpcp_pkg::*;

    logic [CFG_W-1:0] u_xy_reg, u_zc_reg, v_xy_reg, v_zc_reg, d_xy_reg, d_zc_reg;
    logic [DIM_W-1:0] cols_reg, rows_reg;
    logic [DIM_W-1:0] dim_in;

    logic             out_vld_reg;
    logic [PIX_W-1:0] col_reg, row_reg;
    logic             view_reg;

    pipe_ctl_t        in_ctl, mid_ctl;
    logic             dot_vld, div_vld;
    logic signed [SUM_W-1:0] u_sum, v_sum, d_sum;
    logic [PIX_W-1:0] u_quot, v_quot;
    logic             u_ok, v_ok, in_view_next;

    // Advance the whole pipeline unless the output register is stuck.
    assign in_ctl.en   = !out_vld_reg || m_axis_tready;
    assign in_ctl.vld  = s_axis_tvalid;
    assign mid_ctl.en  = in_ctl.en;
    assign mid_ctl.vld = dot_vld;
    assign s_axis_tready = in_ctl.en;

    // Clamp the image size so outputs stay within 13 bits.
    assign dim_in = (cfg_data[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : cfg_data[DIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_xy_reg <= '0;
            u_zc_reg <= '0;
            v_xy_reg <= '0;
            v_zc_reg <= '0;
            d_xy_reg <= '0;
            d_zc_reg <= '0;
            cols_reg <= RESET_COLS;
            rows_reg <= RESET_ROWS;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_U_XY: u_xy_reg <= cfg_data;
                REG_U_ZC: u_zc_reg <= cfg_data;
                REG_V_XY: v_xy_reg <= cfg_data;
                REG_V_ZC: v_zc_reg <= cfg_data;
                REG_D_XY: d_xy_reg <= cfg_data;
                REG_D_ZC: d_zc_reg <= cfg_data;
                REG_COLS: cols_reg <= dim_in;
                REG_ROWS: rows_reg <= dim_in;
                default:  ;
            endcase
        end
    end

    lpcp_dot u_dot_u (
        .clk(clk), .rst_n(rst_n), .ctl(in_ctl),
        .coef_xy(u_xy_reg), .coef_zc(u_zc_reg),
        .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
        .vld(dot_vld), .sum(u_sum)
    );

    lpcp_dot u_dot_v (
        .clk(clk), .rst_n(rst_n), .ctl(in_ctl),
        .coef_xy(v_xy_reg), .coef_zc(v_zc_reg),
        .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
        .vld(), .sum(v_sum)
    );

    lpcp_dot u_dot_d (
        .clk(clk), .rst_n(rst_n), .ctl(in_ctl),
        .coef_xy(d_xy_reg), .coef_zc(d_zc_reg),
        .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
        .vld(), .sum(d_sum)
    );

    lpcp_div u_div_u (
        .clk(clk), .rst_n(rst_n), .ctl(mid_ctl),
        .num(u_sum), .den(d_sum),
        .vld(div_vld), .quot(u_quot), .ok(u_ok)
    );

    lpcp_div u_div_v (
        .clk(clk), .rst_n(rst_n), .ctl(mid_ctl),
        .num(v_sum), .den(d_sum),
        .vld(), .quot(v_quot), .ok(v_ok)
    );

    // Quotient below the bound is the same as U < W*D for integer W.
    assign in_view_next = u_ok && v_ok
                          && (DIM_W'(u_quot) < cols_reg) && (DIM_W'(v_quot) < rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (in_ctl.en)
        begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.en)
        begin
            col_reg  <= in_view_next ? u_quot : '0;
            row_reg  <= in_view_next ? v_quot : '0;
            view_reg <= in_view_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_W - 2 * PIX_W)'(0), row_reg, col_reg};
    assign m_axis_tuser  = view_reg;

endmodule

FILE: design/lpcp_checker.sv
// Port-level checks for the projection top level, bound to every instance.
`timescale 1ns / 1ps
module lpcp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [lpcp_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tuser
);
    import lpcp_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("held result changed");

    // an out-of-view result carries zero pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-view result has nonzero pixels");

    // input is taken whenever the output can move
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output space");

endmodule

bind lidar_point_camera_projection_top lpcp_checker u_lpcp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
